// ----- rtl/pbo_pkg.sv -----
// shared types, constants and helper functions for the periodic box overlap block
// no dependencies; imported by every module of the block
`default_nettype none

package pbo_pkg;

  // coordinate width default and fixed widths of the register fields
  localparam int COORD_BITS_DEF = 32;
  localparam int PERIOD_BITS    = 31;
  localparam int DIMS_BITS      = 2;
  localparam int NUM_AXES       = 3;
  localparam int NUM_FIELDS     = 4 * NUM_AXES;
  localparam int NUM_SHIFTS     = 27;
  localparam int OUT_DATA_BITS  = 8;

  localparam logic [DIMS_BITS-1:0]   DIMS_RESET   = 2'd3;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 31'd16777216;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_DIMS     = 2'd0,
    CFG_PERIOD_X = 2'd1,
    CFG_PERIOD_Y = 2'd2,
    CFG_PERIOD_Z = 2'd3
  } cfg_index_t;

  typedef logic signed [1:0] shift_t;

  // strict overlap along one axis for the first box moved by -1, 0, +1 periods
  typedef struct packed {
    logic pos;
    logic zero;
    logic neg;
  } axis_ok_t;

  typedef struct packed {
    shift_t z;
    shift_t y;
    shift_t x;
  } shift3_t;

  typedef struct packed {
    shift3_t sh;
    logic    overlaps;
  } result_t;

  // shift code 0, 1, 2 stands for -1, 0, +1 periods
  function automatic logic pick_ok(axis_ok_t ok, int code);
    logic r;
    case (code)
      0:       r = ok.neg;
      1:       r = ok.zero;
      default: r = ok.pos;
    endcase
    return r;
  endfunction

  function automatic shift_t code_to_shift(int code);
    return 2'(code - 1);
  endfunction

  // candidate n enumerates x outermost: x code n/9, y code (n/3)%3, z code n%3
  function automatic int x_code(int n);
    return n / 9;
  endfunction

  function automatic int y_code(int n);
    return (n / 3) % 3;
  endfunction

  function automatic int z_code(int n);
    return n % 3;
  endfunction

  function automatic int nonzero_count(int n);
    return int'(x_code(n) != 1) + int'(y_code(n) != 1) + int'(z_code(n) != 1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pbo_axis.sv -----
// per-axis strict overlap flags for the three candidate shifts of the first box
// depends on pbo_pkg
`default_nettype none

module pbo_axis import pbo_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS-1:0]  lo1,
  input  wire logic signed [COORD_BITS-1:0]  hi1,
  input  wire logic signed [COORD_BITS-1:0]  lo2,
  input  wire logic signed [COORD_BITS-1:0]  hi2,
  input  wire logic        [PERIOD_BITS-1:0] period,
  output axis_ok_t                           ok
);

  // wide enough for coordinate plus or minus a period, exactly
  localparam int W = ((COORD_BITS > PERIOD_BITS + 1) ? COORD_BITS : PERIOD_BITS + 1) + 1;

  logic signed [W-1:0] lo1_e, hi1_e, lo2_e, hi2_e, per_e;

  assign lo1_e = $signed({{(W-COORD_BITS){lo1[COORD_BITS-1]}}, lo1});
  assign hi1_e = $signed({{(W-COORD_BITS){hi1[COORD_BITS-1]}}, hi1});
  assign lo2_e = $signed({{(W-COORD_BITS){lo2[COORD_BITS-1]}}, lo2});
  assign hi2_e = $signed({{(W-COORD_BITS){hi2[COORD_BITS-1]}}, hi2});
  assign per_e = $signed({{(W-PERIOD_BITS){1'b0}}, period});

  assign ok.neg  = ((lo1_e - per_e) < hi2_e) && ((hi1_e - per_e) > lo2_e);
  assign ok.zero = (lo1_e < hi2_e) && (hi1_e > lo2_e);
  assign ok.pos  = ((lo1_e + per_e) < hi2_e) && ((hi1_e + per_e) > lo2_e);

endmodule

`default_nettype wire

// ----- rtl/pbo_select.sv -----
// picks the reported shift from the per-axis overlap flags
// depends on pbo_pkg
`default_nettype none

module pbo_select import pbo_pkg::*; (
  input  wire logic [DIMS_BITS-1:0] dims,
  input  wire axis_ok_t             ok_x,
  input  wire axis_ok_t             ok_y,
  input  wire axis_ok_t             ok_z,
  output result_t                   result
);

  logic                  use_y, use_z, direct;
  logic [NUM_SHIFTS-1:0] hit;
  logic                  any_hit  [1:3];
  shift3_t               first_sh [1:3];
  shift3_t               last_sh  [1:3];
  logic [1:0]            best_cnt;
  logic                  found;

  assign use_y  = dims[1];
  assign use_z  = (dims == 2'd3);
  assign direct = ((dims == 2'd0) || ok_x.zero) && (!use_y || ok_y.zero) &&
                  (!use_z || ok_z.zero);

  // overlap test of every shifted candidate, unused y and z axes pinned at zero shift
  always_comb begin
    for (int n = 0; n < NUM_SHIFTS; n++) begin
      hit[n] = (n != 13) &&
               (y_code(n) == 1 || use_y) && (z_code(n) == 1 || use_z) &&
               pick_ok(ok_x, x_code(n)) &&
               (!use_y || pick_ok(ok_y, y_code(n))) &&
               (!use_z || pick_ok(ok_z, z_code(n)));
    end
  end

  // per nonzero count: first and last hit in enumeration order
  always_comb begin
    for (int c = 1; c <= 3; c++) begin
      any_hit[c]  = 1'b0;
      first_sh[c] = '0;
      last_sh[c]  = '0;
    end
    for (int n = 0; n < NUM_SHIFTS; n++) begin
      for (int c = 1; c <= 3; c++) begin
        if (nonzero_count(n) == c && hit[n]) begin
          any_hit[c]   = 1'b1;
          last_sh[c].x = code_to_shift(x_code(n));
          last_sh[c].y = code_to_shift(y_code(n));
          last_sh[c].z = code_to_shift(z_code(n));
        end
      end
    end
    for (int n = NUM_SHIFTS - 1; n >= 0; n--) begin
      for (int c = 1; c <= 3; c++) begin
        if (nonzero_count(n) == c && hit[n]) begin
          first_sh[c].x = code_to_shift(x_code(n));
          first_sh[c].y = code_to_shift(y_code(n));
          first_sh[c].z = code_to_shift(z_code(n));
        end
      end
    end
  end

  always_comb begin
    found    = 1'b1;
    best_cnt = 2'd1;
    if (any_hit[3]) begin
      best_cnt = 2'd3;
    end else if (any_hit[2]) begin
      best_cnt = 2'd2;
    end else if (!any_hit[1]) begin
      found = 1'b0;
    end

    result = '0;
    if (direct) begin
      result.overlaps = 1'b1;
    end else if (found) begin
      result.overlaps = 1'b1;
      // all active axes shifted: earliest wins; otherwise latest of the best count
      if (best_cnt == dims) begin
        case (best_cnt)
          2'd3:    result.sh = first_sh[3];
          2'd2:    result.sh = first_sh[2];
          default: result.sh = first_sh[1];
        endcase
      end else begin
        case (best_cnt)
          2'd3:    result.sh = last_sh[3];
          2'd2:    result.sh = last_sh[2];
          default: result.sh = last_sh[1];
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/periodic_box_overlap_shift.sv -----
// top level of the periodic box overlap test: stream ports, config registers, pipeline
// depends on pbo_pkg, pbo_axis, pbo_select
//
// usage
//   s_* carries box pairs: twelve COORD_BITS-bit signed fixed point coordinates,
//   packed box1_lo_xyz, box1_hi_xyz, box2_lo_xyz, box2_hi_xyz from bit 0 up.
//   m_* returns one result per pair: overlaps flag and a -1..1 shift per axis.
//   cfg_* writes dims (index 0) and the three periods (indexes 1 to 3);
//   cfg_ready is always high, writes are meant for idle periods only.
// timing
//   two register stages: the input register and the result register. an accepted
//   pair moves on to the result register, which drives m_tvalid. one pair per
//   cycle is sustained while m_tready is high; the critical path is the per-axis
//   add and compare of a coordinate with one period and the shift pick.
// stall
//   when the receiver holds m_tready low, the result register keeps its value
//   and the input register can still take one more pair; s_tready falls only
//   when both stages are full and the result is not taken.
// reset
//   rst is synchronous: both stages empty, dims = 3, every period = 1.0.
`default_nettype none

module periodic_box_overlap_shift import pbo_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_BITS   = NUM_FIELDS * COORD_BITS,
  localparam int S_DATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // config write channel
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [PERIOD_BITS-1:0]   cfg_data,
  // input stream
  input  wire logic                     s_tvalid,
  output      logic                     s_tready,
  // box1_lo_x, box1_lo_y, box1_lo_z, box1_hi_x, box1_hi_y, box1_hi_z,
  // box2_lo_x, box2_lo_y, box2_lo_z, box2_hi_x, box2_hi_y, box2_hi_z, zero fill
  input  wire logic [S_DATA_BITS-1:0]   s_tdata,
  // output stream
  output      logic                     m_tvalid,
  input  wire logic                     m_tready,
  // overlaps, shift_x, shift_y, shift_z, one zero bit
  output      logic [OUT_DATA_BITS-1:0] m_tdata
);

  // config registers
  logic [DIMS_BITS-1:0]   dims;
  logic [PERIOD_BITS-1:0] period [NUM_AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        period[a] <= PERIOD_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIMS:     dims      <= cfg_data[DIMS_BITS-1:0];
        CFG_PERIOD_X: period[0] <= cfg_data;
        CFG_PERIOD_Y: period[1] <= cfg_data;
        CFG_PERIOD_Z: period[2] <= cfg_data;
        default:      dims      <= dims;
      endcase
    end
  end

  // pipeline control: result stage advances when empty or taken
  logic    in_valid, out_valid;
  logic    adv_out, adv_in;
  logic [IN_BITS-1:0] in_data;
  result_t res, out_res;

  assign adv_out  = !out_valid || m_tready;
  assign adv_in   = !in_valid || adv_out;
  assign s_tready = adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid <= s_tvalid;
      end
      if (adv_out) begin
        out_valid <= in_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv_in && s_tvalid) begin
      in_data <= s_tdata[IN_BITS-1:0];
    end
    if (adv_out && in_valid) begin
      out_res <= res;
    end
  end

  // per-axis overlap flags
  axis_ok_t ok [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    pbo_axis #(
      .COORD_BITS (COORD_BITS)
    ) u_axis (
      .lo1    (in_data[a * COORD_BITS +: COORD_BITS]),
      .hi1    (in_data[(NUM_AXES + a) * COORD_BITS +: COORD_BITS]),
      .lo2    (in_data[(2 * NUM_AXES + a) * COORD_BITS +: COORD_BITS]),
      .hi2    (in_data[(3 * NUM_AXES + a) * COORD_BITS +: COORD_BITS]),
      .period (period[a]),
      .ok     (ok[a])
    );
  end

  pbo_select u_select (
    .dims   (dims),
    .ok_x   (ok[0]),
    .ok_y   (ok[1]),
    .ok_z   (ok[2]),
    .result (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.sh.z, out_res.sh.y, out_res.sh.x, out_res.overlaps};

  // no overlap always reports zero shift
  a_zero_shift_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.overlaps |-> out_res.sh == '0)
    else $error("nonzero shift reported without overlap");

  // shift codes stay within -1..1
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.sh.x != 2'b10) && (out_res.sh.y != 2'b10) &&
                  (out_res.sh.z != 2'b10))
    else $error("shift code out of range");

  // input blocks only when both stages are full and the result is held
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // an accepted pair occupies the input stage on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted pair lost");

endmodule

`default_nettype wire
